[rtl/tclp_pkg.sv]
package tclp_pkg;

    // Width of the timer field and of every stamp; all stamp math wraps at this width
    localparam int TimerBits    = 16;
    localparam int TiltBits     = 14;
    localparam int HeadingBits  = 16;
    localparam int PeriodBits   = 16;
    localparam int LedCount     = 8;
    localparam int CfgIdxBits   = 1;
    localparam int CfgDataBits  = 16;

    // Register indexes of the configuration port
    localparam logic [CfgIdxBits-1:0] CfgTiltThreshold = 1'd0;
    localparam logic [CfgIdxBits-1:0] CfgPwmPeriod     = 1'd1;

    // Register reset values
    localparam logic [TiltBits-1:0]   TiltThresholdRst = 14'd500;
    localparam logic [PeriodBits-1:0] PwmPeriodRst     = 16'd80;

    // Tilt band limits
    localparam logic [TiltBits-1:0] TiltBand1 = 14'd1500;
    localparam logic [TiltBits-1:0] TiltBand2 = 14'd3000;
    localparam logic [TiltBits-1:0] TiltBand3 = 14'd4500;
    localparam logic [TiltBits-1:0] TiltBand4 = 14'd6000;
    localparam logic [TiltBits-1:0] TiltBand5 = 14'd7500;

    // Heading limit: at or above this the masks are kept
    localparam logic [HeadingBits-1:0] HeadingLimit = 16'd36000;

    typedef logic [LedCount-1:0] t_led;

    typedef struct packed {
        logic [TimerBits-1:0]   timer_now;
        logic [TiltBits-1:0]    tilt;
        logic [HeadingBits-1:0] heading;
    } t_in_item;

    typedef struct packed {
        t_led led_mask;
        logic led_written;
    } t_out_item;

    // One-hot PWM phase
    typedef enum logic [5:0] {
        PH_INIT   = 6'b000001,
        PH_FAR    = 6'b000010,
        PH_MID    = 6'b000100,
        PH_NEAR   = 6'b001000,
        PH_PERIOD = 6'b010000,
        PH_ALLON  = 6'b100000
    } t_phase;

    // Compass octant of a heading below the limit, rounded to the nearest LED
    function automatic logic [2:0] heading_octant(input logic [HeadingBits-1:0] hdg);
        logic [2:0] oct;
        if (hdg < 16'd2250)       oct = 3'd0;
        else if (hdg < 16'd6750)  oct = 3'd1;
        else if (hdg < 16'd11250) oct = 3'd2;
        else if (hdg < 16'd15750) oct = 3'd3;
        else if (hdg < 16'd20250) oct = 3'd4;
        else if (hdg < 16'd24750) oct = 3'd5;
        else if (hdg < 16'd29250) oct = 3'd6;
        else if (hdg < 16'd33750) oct = 3'd7;
        else                      oct = 3'd0;
        return oct;
    endfunction

    // Single LED bit at an octant position
    function automatic t_led led_bit(input logic [2:0] pos);
        return t_led'(1) << pos;
    endfunction

endpackage

[rtl/tilt_compass_led_pwm.sv]
// An input transfer reaches its result through the input register and then the result register.
// Throughput: one item per cycle while the output is not stalled; each item gives exactly one result.
// The input side stalls only while the result register is full and the output is stalled.
// Reset (synchronous, active low): phase to initialize, stamps and masks to zero,
// all LEDs off, level limit 500, pwm_period 80; both pipeline registers empty.
module tilt_compass_led_pwm (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [tclp_pkg::CfgIdxBits-1:0]    i_cfg_idx,
    input  logic [tclp_pkg::CfgDataBits-1:0]   i_cfg_data,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  tclp_pkg::t_in_item                 i_in_item,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output tclp_pkg::t_out_item                o_out_item
);
    import tclp_pkg::*;

    // Configuration registers
    logic [TiltBits-1:0]   r_level_limit;
    logic [PeriodBits-1:0] r_pwm_period;

    // Pipeline registers
    logic      r_s1_vld;
    t_in_item  r_s1_item;
    logic      r_out_vld;
    t_out_item r_out_item;

    // PWM state
    t_phase               r_phase,            n_phase;
    logic [TimerBits-1:0] r_off_stamp_near,   n_off_stamp_near;
    logic [TimerBits-1:0] r_off_stamp_mid,    n_off_stamp_mid;
    logic [TimerBits-1:0] r_off_stamp_far,    n_off_stamp_far;
    logic [TimerBits-1:0] r_period_end_stamp, n_period_end_stamp;
    t_led                 r_mask_near,        n_mask_near;
    t_led                 r_mask_mid,         n_mask_mid;
    t_led                 r_mask_far,         n_mask_far;
    t_led                 r_shown,            n_shown;
    logic                 n_written;

    logic                 out_free;
    logic                 s1_adv;
    logic                 in_xfer;
    logic [TimerBits-1:0] t_now;
    logic                 is_level;
    logic [5:0]           d_near;
    logic [3:0]           d_mid;
    logic [2:0]           oct;

    // Handshake: result register drains or is empty, stage one moves on
    assign out_free    = !r_out_vld || !i_out_stall;
    assign s1_adv      = r_s1_vld && out_free;
    assign o_in_stall  = r_s1_vld && !out_free;
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out_item;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level_limit <= TiltThresholdRst;
            r_pwm_period  <= PwmPeriodRst;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CfgTiltThreshold: r_level_limit <= i_cfg_data[TiltBits-1:0];
                CfgPwmPeriod:     r_pwm_period  <= i_cfg_data[PeriodBits-1:0];
                default: ;
            endcase
        end
    end

    // Tilt band to off-time offsets
    assign t_now    = r_s1_item.timer_now[TimerBits-1:0];
    assign is_level = r_s1_item.tilt < r_level_limit;
    assign oct      = heading_octant(r_s1_item.heading);

    always_comb begin
        priority if (is_level)                     begin d_near = 6'd1;  d_mid = 4'd1;  end
        else if (r_s1_item.tilt < TiltBand1)       begin d_near = 6'd3;  d_mid = 4'd2;  end
        else if (r_s1_item.tilt < TiltBand2)       begin d_near = 6'd6;  d_mid = 4'd2;  end
        else if (r_s1_item.tilt < TiltBand3)       begin d_near = 6'd10; d_mid = 4'd3;  end
        else if (r_s1_item.tilt < TiltBand4)       begin d_near = 6'd20; d_mid = 4'd5;  end
        else if (r_s1_item.tilt < TiltBand5)       begin d_near = 6'd30; d_mid = 4'd8;  end
        else                                       begin d_near = 6'd40; d_mid = 4'd10; end
    end

    // One phase step per item
    always_comb begin
        n_phase            = r_phase;
        n_off_stamp_near   = r_off_stamp_near;
        n_off_stamp_mid    = r_off_stamp_mid;
        n_off_stamp_far    = r_off_stamp_far;
        n_period_end_stamp = r_period_end_stamp;
        n_mask_near        = r_mask_near;
        n_mask_mid         = r_mask_mid;
        n_mask_far         = r_mask_far;
        n_shown            = r_shown;
        n_written          = 1'b0;
        unique case (r_phase)
            PH_INIT: begin
                n_off_stamp_near   = t_now + TimerBits'(d_near);
                n_off_stamp_mid    = t_now + TimerBits'(d_mid);
                n_off_stamp_far    = t_now + TimerBits'(1);
                n_period_end_stamp = t_now + TimerBits'(r_pwm_period);
                n_written          = 1'b1;
                if (is_level) begin
                    n_shown = '1;
                    n_phase = PH_ALLON;
                end else begin
                    if (r_s1_item.heading < HeadingLimit) begin
                        n_mask_near = led_bit(oct);
                        n_mask_mid  = led_bit(oct + 3'd1) | led_bit(oct + 3'd7);
                        n_mask_far  = led_bit(oct + 3'd2) | led_bit(oct + 3'd6);
                    end
                    n_shown = n_mask_near | n_mask_mid | n_mask_far;
                    n_phase = PH_FAR;
                end
            end
            PH_FAR: begin
                if (t_now == r_off_stamp_far) begin
                    n_shown   = r_mask_near | r_mask_mid;
                    n_written = 1'b1;
                    n_phase   = PH_MID;
                end
            end
            PH_MID: begin
                if (t_now == r_off_stamp_mid) begin
                    n_shown   = r_mask_near;
                    n_written = 1'b1;
                    n_phase   = PH_NEAR;
                end
            end
            PH_NEAR: begin
                if (t_now == r_off_stamp_near) begin
                    n_shown   = '0;
                    n_written = 1'b1;
                    n_phase   = (r_period_end_stamp == r_off_stamp_near) ? PH_INIT : PH_PERIOD;
                end
            end
            PH_PERIOD: begin
                if (t_now == r_period_end_stamp) begin
                    n_phase = PH_INIT;
                end
            end
            PH_ALLON: begin
                if (t_now == r_off_stamp_far) begin
                    n_shown   = '0;
                    n_written = 1'b1;
                    n_phase   = PH_PERIOD;
                end
            end
            default: begin
                n_phase = PH_INIT;
            end
        endcase
    end

    // Control: pipeline valids and phase state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld           <= 1'b0;
            r_out_vld          <= 1'b0;
            r_phase            <= PH_INIT;
            r_off_stamp_near   <= '0;
            r_off_stamp_mid    <= '0;
            r_off_stamp_far    <= '0;
            r_period_end_stamp <= '0;
            r_mask_near        <= '0;
            r_mask_mid         <= '0;
            r_mask_far         <= '0;
            r_shown            <= '0;
        end else begin
            if (in_xfer) begin
                r_s1_vld <= 1'b1;
            end else if (s1_adv) begin
                r_s1_vld <= 1'b0;
            end
            if (s1_adv) begin
                r_out_vld          <= 1'b1;
                r_phase            <= n_phase;
                r_off_stamp_near   <= n_off_stamp_near;
                r_off_stamp_mid    <= n_off_stamp_mid;
                r_off_stamp_far    <= n_off_stamp_far;
                r_period_end_stamp <= n_period_end_stamp;
                r_mask_near        <= n_mask_near;
                r_mask_mid         <= n_mask_mid;
                r_mask_far         <= n_mask_far;
                r_shown            <= n_shown;
            end else if (!i_out_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Payload: capture input transfer and result
    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_s1_item <= i_in_item;
        end
        if (s1_adv) begin
            r_out_item.led_mask    <= n_shown;
            r_out_item.led_written <= n_written;
        end
    end

endmodule

[rtl/tclp_checker.sv]
module tclp_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_in_valid,
    input logic                             o_in_stall,
    input logic                             o_out_valid,
    input logic                             i_out_stall,
    input tclp_pkg::t_out_item              o_out_item
);
    import tclp_pkg::*;

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_item))
        else $error("result changed or dropped while stalled");

    // Input back-pressure only comes from a full, stalled result register
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // Nothing is shown right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    // An input transfer becomes a valid result when the output drains after it
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall ##1 !i_out_stall |=> o_out_valid)
        else $error("result missing after input transfer");

endmodule

bind tilt_compass_led_pwm tclp_checker u_tclp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_item  (o_out_item)
);
